>>> rtl/ssg_pkg.sv
// Shared types, constants and modular arithmetic for the GF(251) share generator.
package ssg_pkg;

  localparam logic [8:0] Prime = 9'd251;
  localparam int NumInCoefs = 8;

  localparam logic [1:0] CfgShareCount = 2'd0;
  localparam logic [1:0] CfgThreshold  = 2'd1;

  typedef struct packed {
    logic [7:0] secret;
    logic [7:0] coef_1;
    logic [7:0] coef_2;
    logic [7:0] coef_3;
    logic [7:0] coef_4;
    logic [7:0] coef_5;
    logic [7:0] coef_6;
    logic [7:0] coef_7;
  } in_word_t;

  typedef struct packed {
    logic [6:0] share_number;
    logic [7:0] share_value;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [6:0] x;
  } ctl_t;

  function automatic logic [7:0] mul_mod(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    logic [10:0] t1;
    logic [8:0]  t2;
    p  = a * b;
    t1 = {3'b000, p[7:0]} + 11'(p[15:8]) * 11'd5;
    t2 = {1'b0, t1[7:0]} + 9'(t1[10:8]) * 9'd5;
    if (t2 >= Prime) begin
      t2 = t2 - Prime;
    end
    return t2[7:0];
  endfunction

endpackage

>>> rtl/ssg_seq.sv
// Item register and share point sequencer: loads coefficients and issues x = 1..n.
module ssg_seq #(
  parameter int MAX_THRESHOLD = 8,
  parameter int MAX_SHARES    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssg_pkg::in_word_t in_word_i,
  input  logic [6:0]        share_count_i,
  input  logic [3:0]        threshold_i,
  input  logic              adv_i,
  output ssg_pkg::ctl_t     ctl_o,
  output logic [7:0]        coef_o [MAX_THRESHOLD],
  output logic [7:0]        pw_o   [MAX_THRESHOLD]
);

  localparam int RawN = (MAX_THRESHOLD > ssg_pkg::NumInCoefs) ?
                        MAX_THRESHOLD : ssg_pkg::NumInCoefs;

  logic       busy_q, busy_d;
  logic [6:0] x_q, x_d;
  logic [6:0] n_q, n_d;
  logic [7:0] coef_q [MAX_THRESHOLD];
  logic [7:0] coef_d [MAX_THRESHOLD];
  logic [7:0] raw [RawN];
  logic [4:0] thr5, k_c;
  logic       last_now, accept;

  function automatic logic [7:0] red251(input logic [7:0] c);
    logic [8:0] w;
    w = {1'b0, c};
    if (w >= ssg_pkg::Prime) begin
      w = w - ssg_pkg::Prime;
    end
    return w[7:0];
  endfunction

  assign last_now   = (x_q == n_q);
  assign in_stall_o = busy_q && !(adv_i && last_now);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    for (int j = 0; j < RawN; j++) begin
      raw[j] = 8'd0;
    end
    raw[0] = (in_word_i.secret > 8'd250) ? 8'd250 : in_word_i.secret;
    raw[1] = in_word_i.coef_1;
    raw[2] = in_word_i.coef_2;
    raw[3] = in_word_i.coef_3;
    raw[4] = in_word_i.coef_4;
    raw[5] = in_word_i.coef_5;
    raw[6] = in_word_i.coef_6;
    raw[7] = in_word_i.coef_7;

    thr5 = {1'b0, threshold_i};
    if (thr5 == 5'd0) begin
      k_c = 5'd1;
    end else if (thr5 > 5'(MAX_THRESHOLD)) begin
      k_c = 5'(MAX_THRESHOLD);
    end else begin
      k_c = thr5;
    end

    busy_d = busy_q;
    x_d    = x_q;
    n_d    = n_q;
    for (int j = 0; j < MAX_THRESHOLD; j++) begin
      coef_d[j] = coef_q[j];
    end

    if (busy_q && adv_i) begin
      x_d = x_q + 7'd1;
      if (last_now) begin
        busy_d = 1'b0;
      end
    end

    if (accept) begin
      busy_d = 1'b1;
      x_d    = 7'd1;
      if (share_count_i == 7'd0) begin
        n_d = 7'd1;
      end else if (share_count_i > 7'(MAX_SHARES)) begin
        n_d = 7'(MAX_SHARES);
      end else begin
        n_d = share_count_i;
      end
      for (int j = 0; j < MAX_THRESHOLD; j++) begin
        coef_d[j] = (5'(j) < k_c) ? red251(raw[j]) : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      x_q    <= 7'd1;
      n_q    <= 7'd1;
    end else begin
      busy_q <= busy_d;
      x_q    <= x_d;
      n_q    <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_THRESHOLD; j++) begin
      coef_q[j] <= coef_d[j];
    end
  end

  always_comb begin
    ctl_o.valid = busy_q;
    ctl_o.last  = last_now;
    ctl_o.x     = x_q;
    for (int j = 0; j < MAX_THRESHOLD; j++) begin
      coef_o[j] = coef_q[j];
      pw_o[j]   = 8'd0;
    end
    pw_o[0] = 8'd1;
  end

  a_point_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (x_q != 7'd0) && (x_q <= n_q))
    else $error("share point outside 1..n");

  a_point_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && adv_i && !last_now) |=> busy_q && (x_q == $past(x_q) + 7'd1))
    else $error("share point did not advance by one");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && (x_q == 7'd1))
    else $error("accepted word did not start at point one");

endmodule

>>> rtl/ssg_pow.sv
// One power stage: extends the carried power list by x^S mod 251.
module ssg_pow #(
  parameter int MAX_THRESHOLD = 8,
  parameter int S             = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  ssg_pkg::ctl_t ctl_i,
  input  logic [7:0]    coef_i [MAX_THRESHOLD],
  input  logic [7:0]    pw_i   [MAX_THRESHOLD],
  output ssg_pkg::ctl_t ctl_o,
  output logic [7:0]    coef_o [MAX_THRESHOLD],
  output logic [7:0]    pw_o   [MAX_THRESHOLD]
);

  ssg_pkg::ctl_t ctl_q;
  logic [7:0]    coef_q [MAX_THRESHOLD];
  logic [7:0]    pw_q   [MAX_THRESHOLD];
  logic [7:0]    pw_d   [MAX_THRESHOLD];

  always_comb begin
    for (int j = 0; j < MAX_THRESHOLD; j++) begin
      pw_d[j] = pw_i[j];
    end
    pw_d[S] = ssg_pkg::mul_mod(pw_i[S-1], {1'b0, ctl_i.x});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < MAX_THRESHOLD; j++) begin
        coef_q[j] <= coef_i[j];
        pw_q[j]   <= pw_d[j];
      end
    end
  end

  assign ctl_o = ctl_q;

  always_comb begin
    for (int j = 0; j < MAX_THRESHOLD; j++) begin
      coef_o[j] = coef_q[j];
      pw_o[j]   = pw_q[j];
    end
  end

endmodule

>>> rtl/ssg_lane.sv
// One term lane: registers coefficient times power, mod 251.
module ssg_lane (
  input  logic       clk_i,
  input  logic       adv_i,
  input  logic [7:0] coef_i,
  input  logic [7:0] pw_i,
  output logic [7:0] term_o
);

  logic [7:0] term_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      term_q <= ssg_pkg::mul_mod(coef_i, pw_i);
    end
  end

  assign term_o = term_q;

endmodule

>>> rtl/ssg_merge.sv
// Merge stage: sums lane terms mod 251 into the output word register.
module ssg_merge #(
  parameter int MAX_THRESHOLD = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  ssg_pkg::ctl_t      ctl_i,
  input  logic [7:0]         term_i [MAX_THRESHOLD],
  output logic               out_valid_o,
  output ssg_pkg::out_word_t out_word_o
);

  localparam int SW = 8 + $clog2(MAX_THRESHOLD);

  logic [SW-1:0]      sum;
  logic [8:0]         fold;
  logic               valid_q;
  ssg_pkg::out_word_t word_q, word_d;

  always_comb begin
    sum = '0;
    for (int j = 0; j < MAX_THRESHOLD; j++) begin
      sum = sum + SW'(term_i[j]);
    end
    fold = {1'b0, sum[7:0]} + 9'(sum[SW-1:8]) * 9'd5;
    if (fold >= ssg_pkg::Prime) begin
      fold = fold - ssg_pkg::Prime;
    end
    word_d.share_number = ctl_i.x;
    word_d.share_value  = fold[7:0];
    word_d.last         = ctl_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> rtl/shamir_share_generator_gf251.sv
// Top level of the GF(251) share generator: config registers, power pipeline, lanes, merge.
// Shares pass the sequencer, the power stages, the lane registers and the merge register.
// One share per cycle unless out_stall_i stalls; n = clamped share_count shares per word.
// The next word is taken in the cycle the last share of the previous one issues.
// Reset: share_count 5, threshold 3, pipeline empty, no clearing pass.
module shamir_share_generator_gf251 #(
  parameter int MAX_THRESHOLD = 8,
  parameter int MAX_SHARES    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ssg_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssg_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);

  logic [6:0]    share_count_q;
  logic [3:0]    threshold_q;
  logic          adv;
  ssg_pkg::ctl_t ctl_s  [MAX_THRESHOLD];
  logic [7:0]    coef_s [MAX_THRESHOLD][MAX_THRESHOLD];
  logic [7:0]    pw_s   [MAX_THRESHOLD][MAX_THRESHOLD];
  ssg_pkg::ctl_t ctl_lane_q;
  logic [7:0]    term   [MAX_THRESHOLD];

  assign cfg_ready_o = 1'b1;
  assign adv = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      share_count_q <= 7'd5;
      threshold_q   <= 4'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ssg_pkg::CfgShareCount: share_count_q <= cfg_data_i;
        ssg_pkg::CfgThreshold:  threshold_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  ssg_seq #(
    .MAX_THRESHOLD(MAX_THRESHOLD),
    .MAX_SHARES   (MAX_SHARES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .share_count_i(share_count_q),
    .threshold_i  (threshold_q),
    .adv_i        (adv),
    .ctl_o        (ctl_s[0]),
    .coef_o       (coef_s[0]),
    .pw_o         (pw_s[0])
  );

  for (genvar s = 1; s < MAX_THRESHOLD; s++) begin : g_pow
    ssg_pow #(
      .MAX_THRESHOLD(MAX_THRESHOLD),
      .S            (s)
    ) u_pow (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (ctl_s[s-1]),
      .coef_i(coef_s[s-1]),
      .pw_i  (pw_s[s-1]),
      .ctl_o (ctl_s[s]),
      .coef_o(coef_s[s]),
      .pw_o  (pw_s[s])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_lane_q <= '0;
    end else if (adv) begin
      ctl_lane_q <= ctl_s[MAX_THRESHOLD-1];
    end
  end

  for (genvar j = 0; j < MAX_THRESHOLD; j++) begin : g_lane
    ssg_lane u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .coef_i(coef_s[MAX_THRESHOLD-1][j]),
      .pw_i  (pw_s[MAX_THRESHOLD-1][j]),
      .term_o(term[j])
    );
  end

  ssg_merge #(
    .MAX_THRESHOLD(MAX_THRESHOLD)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .ctl_i      (ctl_lane_q),
    .term_i     (term),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o)
  );

endmodule

>>> tb/sv/tb_shamir_share_generator_gf251.sv
// Self-checking testbench for the GF(251) share generator: directed table, random words, stalls.
module tb_shamir_share_generator_gf251;

  localparam int MaxThreshold = 8;
  localparam int MaxShares    = 64;
  localparam int FieldPrime   = 251;
  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles   = 250;
  localparam int NumRows      = 16;
  localparam int WordsPerSeg  = 28;
  localparam logic [1:0] CfgUnused2 = 2'd2;
  localparam logic [1:0] CfgUnused3 = 2'd3;

  typedef struct {
    logic [6:0]        share_count;
    logic [6:0]        threshold;
    ssg_pkg::in_word_t word;
    bit                value_known;
    logic [7:0]        value;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  ssg_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ssg_pkg::out_word_t out_word_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [6:0]         cfg_data_i  = '0;

  logic [6:0]         cur_share_count = 7'd5;
  logic [3:0]         cur_threshold   = 4'd3;
  ssg_pkg::out_word_t pending_shares[$];
  int                 mismatch_count = 0;
  int                 in_idle_pct  = 0;
  int                 out_idle_pct = 0;
  int                 hold_asks = 0;

  dir_row_t dir_rows [NumRows] = '{
    '{7'd5,   7'd3,   64'h0000_0000_0000_0000, 1'b1, 8'd0},
    '{7'd5,   7'd3,   64'hFF00_0000_0000_0000, 1'b1, 8'd250},
    '{7'd5,   7'd3,   64'hFB01_0203_0405_0607, 1'b0, 8'd0},
    '{7'd5,   7'd3,   64'hFAFA_FAFA_FAFA_FAFA, 1'b0, 8'd0},
    '{7'd1,   7'd1,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd250},
    '{7'd0,   7'd0,   64'h07FF_FFFF_FFFF_FFFF, 1'b1, 8'd7},
    '{7'd64,  7'd8,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0},
    '{7'd127, 7'd15,  64'hC8FF_FEFD_FCFB_FAF9, 1'b0, 8'd0},
    '{7'd127, 7'h70,  64'hFB12_3456_789A_BCDE, 1'b1, 8'd250},
    '{7'd3,   7'd2,   64'h00FF_0000_0000_0000, 1'b0, 8'd0},
    '{7'd3,   7'd2,   64'h1122_FFFF_FFFF_FFFF, 1'b0, 8'd0},
    '{7'd8,   7'd8,   64'h0001_0203_0405_0607, 1'b0, 8'd0},
    '{7'd8,   7'd8,   64'h5501_0000_0000_0000, 1'b0, 8'd0},
    '{7'd64,  7'd4,   64'hAA55_AA55_AA55_AA55, 1'b0, 8'd0},
    '{7'd2,   7'd8,   64'hFFFB_FCFD_FEFF_FAF9, 1'b0, 8'd0},
    '{7'd5,   7'd3,   64'h3C00_0000_0000_0000, 1'b1, 8'd60}
  };

  shamir_share_generator_gf251 #(
    .MAX_THRESHOLD(MaxThreshold),
    .MAX_SHARES   (MaxShares)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void queue_shares(ssg_pkg::in_word_t w, bit value_known,
                                       logic [7:0] value);
    int n;
    int k;
    int acc;
    int coefs[MaxThreshold];
    ssg_pkg::out_word_t share;
    n = cur_share_count;
    k = cur_threshold;
    if (n == 0) n = 1;
    if (n > MaxShares) n = MaxShares;
    if (k == 0) k = 1;
    if (k > MaxThreshold) k = MaxThreshold;
    coefs[0] = (w.secret > 8'd250) ? 250 : w.secret;
    coefs[1] = w.coef_1;
    coefs[2] = w.coef_2;
    coefs[3] = w.coef_3;
    coefs[4] = w.coef_4;
    coefs[5] = w.coef_5;
    coefs[6] = w.coef_6;
    coefs[7] = w.coef_7;
    for (int x = 1; x <= n; x++) begin
      acc = 0;
      for (int i = k - 1; i >= 0; i--) begin
        acc = (acc * x + coefs[i] % FieldPrime) % FieldPrime;
      end
      share.share_number = 7'(x);
      share.share_value  = value_known ? value : 8'(acc);
      share.last         = (x == n);
      pending_shares.push_back(share);
    end
  endfunction

  task automatic send_word(ssg_pkg::in_word_t w, bit value_known, logic [7:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    queue_shares(w, value_known, value);
  endtask

  task automatic drain_shares();
    in_valid_i <= 1'b0;
    while (pending_shares.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ssg_pkg::CfgShareCount: cur_share_count = data;
      ssg_pkg::CfgThreshold:  cur_threshold   = data[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [6:0] share_count, logic [6:0] threshold);
    drain_shares();
    write_reg(ssg_pkg::CfgShareCount, share_count);
    write_reg(ssg_pkg::CfgThreshold, threshold);
    write_reg(CfgUnused2, 7'($urandom));
    write_reg(CfgUnused3, 7'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : share_check
    ssg_pkg::out_word_t exp_share;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_shares.size() == 0) begin
        $error("share_number: expected none, got %0d", out_word_o.share_number);
        mismatch_count++;
      end else begin
        exp_share = pending_shares.pop_front();
        if (out_word_o.share_number !== exp_share.share_number) begin
          $error("share_number: expected %0d, got %0d",
                 exp_share.share_number, out_word_o.share_number);
          mismatch_count++;
        end
        if (out_word_o.share_value !== exp_share.share_value) begin
          $error("share_value: expected %0d, got %0d",
                 exp_share.share_value, out_word_o.share_value);
          mismatch_count++;
        end
        if (out_word_o.last !== exp_share.last) begin
          $error("last: expected %0d, got %0d", exp_share.last, out_word_o.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("** shamir_share_generator_gf251: FAILED **");
    $finish;
  end

  initial begin
    logic [6:0]        share_count;
    ssg_pkg::in_word_t w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct  = 35;
    out_idle_pct = 49;
    for (int r = 0; r < NumRows; r++) begin
      if (dir_rows[r].share_count != cur_share_count ||
          dir_rows[r].threshold[3:0] != cur_threshold) begin
        apply_config(dir_rows[r].share_count, dir_rows[r].threshold);
      end
      send_word(dir_rows[r].word, dir_rows[r].value_known, dir_rows[r].value);
    end

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 35 : (ph == 1) ? 49 : 0;
      out_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 35 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(7))
          0:       share_count = 7'd0;
          1:       share_count = 7'd64;
          2:       share_count = 7'd127;
          3:       share_count = 7'($urandom_range(65, 126));
          default: share_count = 7'($urandom_range(1, 8));
        endcase
        apply_config(share_count, {3'($urandom), 4'($urandom_range(15))});
        if (ph == 2 && seg == 0) begin
          hold_asks <= hold_asks + 1;
        end
        for (int i = 0; i < WordsPerSeg; i++) begin
          w = {$urandom, $urandom};
          send_word(w, 1'b0, 8'd0);
        end
      end
    end

    drain_shares();
    repeat (MaxThreshold + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** shamir_share_generator_gf251: PASSED **");
    end else begin
      $display("** shamir_share_generator_gf251: FAILED **");
    end
    $finish;
  end

endmodule

>>> shamir_share_generator_gf251.f
rtl/ssg_pkg.sv
rtl/ssg_seq.sv
rtl/ssg_pow.sv
rtl/ssg_lane.sv
rtl/ssg_merge.sv
rtl/shamir_share_generator_gf251.sv
tb/sv/tb_shamir_share_generator_gf251.sv
